@@ hdl/scm_pkg.sv @@
// shared types and constants of the sector cache map
package scm_pkg;

  localparam int STAMP_W = 64;
  localparam int COUNT_W = 16;
  localparam int STAT_W  = 32;
  localparam int CAP_W   = 7;
  localparam int MODE_W  = 2;
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 6;
  localparam int USED_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_DIRTY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK_CLEAN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

  localparam logic [MODE_W-1:0] MODE_LRU  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LFU  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIFO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [STAT_W-1:0]  STAT_MAX  = '1;

  typedef struct packed {
    logic [STAMP_W-1:0] rec;
    logic [STAMP_W-1:0] ins;
    logic [COUNT_W-1:0] cnt;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    return (v == STAT_MAX) ? v : v + STAT_W'(1);
  endfunction

endpackage

@@ hdl/scm_in_if.sv @@
// command channel: valid/ready with command and sector
interface scm_in_if #(parameter int SECTOR_BITS = 48);
  logic                        valid;
  logic                        ready;
  logic [scm_pkg::CMD_W-1:0]   command;
  logic [SECTOR_BITS-1:0]      sector;
  modport source (output valid, command, sector, input ready);
  modport sink   (input valid, command, sector, output ready);
endinterface

@@ hdl/scm_out_if.sv @@
// result channel: valid/ready with lookup result and statistics
interface scm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [scm_pkg::SLOT_W-1:0]   slot;
  logic                         evicted;
  logic [scm_pkg::USED_W-1:0]   used_count;
  logic [scm_pkg::STAT_W-1:0]   hit_total;
  logic [scm_pkg::STAT_W-1:0]   miss_total;
  logic [scm_pkg::STAT_W-1:0]   evict_total;
  modport source (output valid, found, slot, evicted, used_count, hit_total, miss_total,
                  evict_total, input ready);
  modport sink   (input valid, found, slot, evicted, used_count, hit_total, miss_total,
                  evict_total, output ready);
endinterface

@@ hdl/scm_cfg_if.sv @@
// configuration write channel
interface scm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [scm_pkg::CFG_IDX_W-1:0]    index;
  logic [scm_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/scm_ram.sv @@
// generic single write, single read ram with registered read data
module scm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/scm_cmp.sv @@
// victim compare unit: is the candidate a better victim than the current best
module scm_cmp (
  input  logic [scm_pkg::MODE_W-1:0] mode,
  input  scm_pkg::meta_t             cand,
  input  scm_pkg::meta_t             best,
  output logic                       better
);

  always_comb begin
    case (mode)
      scm_pkg::MODE_LFU: begin
        better = (cand.cnt < best.cnt) || ((cand.cnt == best.cnt) && (cand.rec < best.rec));
      end
      scm_pkg::MODE_FIFO: begin
        better = cand.ins < best.ins;
      end
      default: begin
        better = cand.rec < best.rec;
      end
    endcase
  end

endmodule

@@ hdl/sector_cache_map_replacement.sv @@
// top level: fully associative sector map with lru, lfu and fifo replacement
// one command at a time: the next is taken only back in idle, after the one-slot-a-cycle table scan
// through the slot ram read port and the shared victim compare unit
// reset: synchronous active low; clears valid and dirty bits, counters and statistics,
// capacity returns to 64 and policy to lru; slot ram contents are left as they are
module sector_cache_map_replacement #(
  parameter int ENTRIES     = 64,
  parameter int SECTOR_BITS = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  scm_in_if.sink        in_chan,
  scm_out_if.source     out_chan,
  scm_cfg_if.sink       cfg_chan
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > scm_pkg::CAP_W) ? OCC_W : scm_pkg::CAP_W;
  localparam int WORD_W = SECTOR_BITS + scm_pkg::META_W;

  scm_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]              cnt_r;
  logic                          pend_r;
  logic [IDX_W-1:0]              pidx_r;
  logic [scm_pkg::CMD_W-1:0]     cmd_r;
  logic [SECTOR_BITS-1:0]        sec_r;

  logic                          hit_f_r;
  logic [IDX_W-1:0]              hit_idx_r;
  scm_pkg::meta_t                hit_meta_r;
  logic                          free_f_r;
  logic [IDX_W-1:0]              free_idx_r;
  logic                          vic_f_r;
  logic [IDX_W-1:0]              vic_idx_r;
  scm_pkg::meta_t                vic_meta_r;

  logic [ENTRIES-1:0]            valid_r;
  logic [ENTRIES-1:0]            dirty_r;
  logic [scm_pkg::STAMP_W-1:0]   stamp_r;
  logic [OCC_W-1:0]              occ_r;
  logic [scm_pkg::STAT_W-1:0]    hits_r;
  logic [scm_pkg::STAT_W-1:0]    misses_r;
  logic [scm_pkg::STAT_W-1:0]    evs_r;
  logic [scm_pkg::CAP_W-1:0]     cap_r;
  logic [scm_pkg::MODE_W-1:0]    mode_r;

  logic                          ov_r;
  logic                          o_found_r;
  logic [scm_pkg::SLOT_W-1:0]    o_slot_r;
  logic                          o_evicted_r;
  logic [scm_pkg::USED_W-1:0]    o_used_r;

  // sequencer outputs
  logic                          in_rdy;
  logic                          issue;
  logic                          finish;
  logic                          out_free;

  // scan datapath
  logic [WORD_W-1:0]             rd_word;
  logic [SECTOR_BITS-1:0]        rd_sec;
  scm_pkg::meta_t                rd_meta;
  logic                          rd_vld;
  logic                          cand_better;

  // decision
  logic [CW-1:0]                 cap_eff;
  logic                          is_lookup;
  logic                          is_insert;
  logic                          do_ref;
  logic                          do_evict;
  logic                          do_new;
  logic [IDX_W-1:0]              new_idx;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [WORD_W-1:0]             ram_wdata;
  scm_pkg::meta_t                ref_meta;
  scm_pkg::meta_t                new_meta;

  assign out_free = !ov_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scm_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = scm_pkg::ST_SCAN;
        end
      end
      scm_pkg::ST_SCAN: begin
        if (cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = scm_pkg::ST_LAST;
        end
      end
      scm_pkg::ST_LAST: begin
        state_nxt = scm_pkg::ST_DONE;
      end
      scm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = scm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_rdy = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    case (state_r)
      scm_pkg::ST_IDLE: in_rdy = 1'b1;
      scm_pkg::ST_SCAN: issue  = 1'b1;
      scm_pkg::ST_DONE: finish = out_free;
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  assign in_chan.ready  = in_rdy;
  assign cfg_chan.ready = 1'b1;

  scm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r),
    .rdata (rd_word)
  );

  assign rd_sec  = rd_word[WORD_W-1 -: SECTOR_BITS];
  assign rd_meta = rd_word[scm_pkg::META_W-1:0];
  assign rd_vld  = valid_r[pidx_r];

  scm_cmp u_cmp (
    .mode   (mode_r),
    .cand   (rd_meta),
    .best   (vic_meta_r),
    .better (cand_better)
  );

  // effective capacity: zero acts as one, above the table size acts as the table size
  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(cap_r) > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end

  always_comb begin
    is_lookup = cmd_r == scm_pkg::CMD_LOOKUP;
    is_insert = cmd_r == scm_pkg::CMD_INSERT;
    do_ref    = (is_lookup || is_insert) && hit_f_r;
    do_evict  = is_insert && !hit_f_r && (CW'(occ_r) >= cap_eff) && vic_f_r;
    do_new    = is_insert && !hit_f_r && (do_evict || free_f_r);
    new_idx   = do_evict ? vic_idx_r : free_idx_r;

    ref_meta.rec = stamp_r;
    ref_meta.ins = hit_meta_r.ins;
    ref_meta.cnt = (hit_meta_r.cnt == scm_pkg::COUNT_MAX) ? hit_meta_r.cnt
                                                          : hit_meta_r.cnt + 16'd1;
    new_meta.rec = stamp_r;
    new_meta.ins = stamp_r;
    new_meta.cnt = scm_pkg::COUNT_W'(1);

    ram_we    = finish && (do_ref || do_new);
    ram_waddr = do_ref ? hit_idx_r : new_idx;
    ram_wdata = do_ref ? {sec_r, ref_meta} : {sec_r, new_meta};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= scm_pkg::ST_IDLE;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      valid_r  <= '0;
      dirty_r  <= '0;
      stamp_r  <= '0;
      occ_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evs_r    <= '0;
      cap_r    <= scm_pkg::CAP_W'(64);
      mode_r   <= scm_pkg::MODE_LRU;
      ov_r     <= 1'b0;
      hit_f_r  <= 1'b0;
      free_f_r <= 1'b0;
      vic_f_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      pidx_r  <= cnt_r;

      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          scm_pkg::REG_CAPACITY: cap_r  <= cfg_chan.data;
          scm_pkg::REG_MODE:     mode_r <= cfg_chan.data[scm_pkg::MODE_W-1:0];
          default: begin
            cap_r <= cap_r;
          end
        endcase
      end

      if (in_rdy && in_chan.valid) begin
        cmd_r    <= in_chan.command;
        sec_r    <= in_chan.sector;
        cnt_r    <= '0;
        hit_f_r  <= 1'b0;
        free_f_r <= 1'b0;
        vic_f_r  <= 1'b0;
      end else if (issue && cnt_r != IDX_W'(ENTRIES - 1)) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end

      // one slot a cycle through the compare unit, strict compares keep the lowest slot
      if (pend_r) begin
        if (rd_vld && rd_sec == sec_r && !hit_f_r) begin
          hit_f_r    <= 1'b1;
          hit_idx_r  <= pidx_r;
          hit_meta_r <= rd_meta;
        end
        if (!rd_vld && !free_f_r) begin
          free_f_r   <= 1'b1;
          free_idx_r <= pidx_r;
        end
        if (rd_vld && (!vic_f_r || cand_better)) begin
          vic_f_r    <= 1'b1;
          vic_idx_r  <= pidx_r;
          vic_meta_r <= rd_meta;
        end
      end

      if (ov_r && out_chan.ready) begin
        ov_r <= 1'b0;
      end

      if (finish) begin
        ov_r        <= 1'b1;
        o_found_r   <= (cmd_r <= scm_pkg::CMD_INVALIDATE) && hit_f_r;
        o_evicted_r <= do_evict;
        o_slot_r    <= do_ref ? scm_pkg::SLOT_W'(hit_idx_r)
                     : (do_new ? scm_pkg::SLOT_W'(new_idx) : '0);
        o_used_r    <= scm_pkg::USED_W'(occ_r);

        if (do_ref || do_new) begin
          stamp_r <= stamp_r + scm_pkg::STAMP_W'(1);
        end
        if (is_lookup) begin
          if (hit_f_r) begin
            hits_r <= scm_pkg::sat_inc(hits_r);
          end else begin
            misses_r <= scm_pkg::sat_inc(misses_r);
          end
        end
        if (do_new) begin
          valid_r[new_idx] <= 1'b1;
          dirty_r[new_idx] <= 1'b0;
          if (do_evict) begin
            evs_r <= scm_pkg::sat_inc(evs_r);
          end else begin
            occ_r    <= occ_r + OCC_W'(1);
            o_used_r <= scm_pkg::USED_W'(occ_r + OCC_W'(1));
          end
        end

        case (cmd_r)
          scm_pkg::CMD_MARK_DIRTY: begin
            if (hit_f_r) dirty_r[hit_idx_r] <= 1'b1;
          end
          scm_pkg::CMD_MARK_CLEAN: begin
            if (hit_f_r) dirty_r[hit_idx_r] <= 1'b0;
          end
          scm_pkg::CMD_INVALIDATE: begin
            if (hit_f_r) begin
              valid_r[hit_idx_r] <= 1'b0;
              dirty_r[hit_idx_r] <= 1'b0;
              occ_r              <= occ_r - OCC_W'(1);
              o_used_r           <= scm_pkg::USED_W'(occ_r - OCC_W'(1));
            end
          end
          scm_pkg::CMD_CLEAR: begin
            valid_r  <= '0;
            dirty_r  <= '0;
            occ_r    <= '0;
            o_used_r <= '0;
            hits_r   <= '0;
            misses_r <= '0;
            evs_r    <= '0;
            stamp_r  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.found       = o_found_r;
  assign out_chan.slot        = o_slot_r;
  assign out_chan.evicted     = o_evicted_r;
  assign out_chan.used_count  = o_used_r;
  assign out_chan.hit_total   = hits_r;
  assign out_chan.miss_total  = misses_r;
  assign out_chan.evict_total = evs_r;

`ifndef SYNTH
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == scm_pkg::ST_DONE))
    else $error("result beat raised outside the finish step");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(ENTRIES))
    else $error("occupancy above table size");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (!pend_r && !issue))
    else $error("command beat taken during a scan");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && do_evict) |=> (occ_r == $past(occ_r)))
    else $error("eviction changed occupancy");
`endif

endmodule
